[sv/dttv_pkg.sv]
// package with the shared types, constants and helper functions of the date/time validator
`timescale 1ns / 1ps

package dttv_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned FIELD_W  = 7;
	localparam int unsigned POS_W    = 5;

	localparam logic [POS_W-1:0] TEXT_LEN  = 5'd16;
	localparam logic [POS_W-1:0] POS_SAT   = 5'd17;

	localparam logic [POS_W-1:0] POS_SLASH_A  = 5'd2;
	localparam logic [POS_W-1:0] POS_SLASH_B  = 5'd5;
	localparam logic [POS_W-1:0] POS_SPACE    = 5'd10;
	localparam logic [POS_W-1:0] POS_COLON    = 5'd13;
	localparam logic [POS_W-1:0] POS_DAY_END  = 5'd1;
	localparam logic [POS_W-1:0] POS_MON_END  = 5'd4;
	localparam logic [POS_W-1:0] POS_CENT_END = 5'd7;
	localparam logic [POS_W-1:0] POS_YEAR_END = 5'd9;
	localparam logic [POS_W-1:0] POS_HOUR_END = 5'd12;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3a;

	localparam logic [FIELD_W-1:0] MONTH_FEB   = 7'd2;
	localparam logic [FIELD_W-1:0] MONTH_FIRST = 7'd1;
	localparam logic [FIELD_W-1:0] MONTH_LAST  = 7'd12;
	localparam logic [FIELD_W-1:0] DAY_FIRST   = 7'd1;
	localparam logic [FIELD_W-1:0] FEB_LEAP    = 7'd29;
	localparam logic [FIELD_W-1:0] FEB_COMMON  = 7'd28;
	localparam logic [FIELD_W-1:0] HOUR_MAX    = 7'd23;
	localparam logic [FIELD_W-1:0] MINUTE_MAX  = 7'd59;

	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1900;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2100;

	// register index taken from paddr[2]
	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	typedef enum logic [1:0] {
		STATUS_VALID  = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_DATE   = 2'd2,
		STATUS_TIME   = 2'd3
	} status_t;

	// parsed text handed from the parser to the checker
	typedef struct packed {
		logic               fmt_ok;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] cent;
		logic [FIELD_W-1:0] yr_lo;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
	} rec_t;

	typedef struct packed {
		logic [YEAR_W-1:0] min_year;
		logic [YEAR_W-1:0] max_year;
	} cfg_t;

	function automatic logic [FIELD_W-1:0] mul10_add7(input logic [FIELD_W-1:0] acc,
		input logic [3:0] d);
		mul10_add7 = (acc << 3) + (acc << 1) + {3'b000, d};
	endfunction

	function automatic logic [YEAR_W-1:0] mul10_add14(input logic [YEAR_W-1:0] acc,
		input logic [3:0] d);
		mul10_add14 = (acc << 3) + (acc << 1) + {10'd0, d};
	endfunction

	function automatic logic [FIELD_W-1:0] month_days(input logic [FIELD_W-1:0] m);
		case (m)
			7'd4, 7'd6, 7'd9, 7'd11: month_days = 7'd30;
			7'd2:                    month_days = FEB_COMMON;
			default:                 month_days = 7'd31;
		endcase
	endfunction

endpackage

[sv/dttv_cfg.sv]
// configuration registers with the apb-style write and read port
`timescale 1ns / 1ps

module dttv_cfg
	import dttv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] max_year_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MIN_YEAR: min_year_q <= pwdata[YEAR_W-1:0];
				REG_MAX_YEAR: max_year_q <= pwdata[YEAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MIN_YEAR: prdata = {18'd0, min_year_q};
			REG_MAX_YEAR: prdata = {18'd0, max_year_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.min_year = min_year_q;
	assign cfg.max_year = max_year_q;

endmodule

[sv/dttv_parse.sv]
// character input register, position check and decimal field accumulators
`timescale 1ns / 1ps

module dttv_parse
	import dttv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       rec_valid,
	input  logic       rec_ready,
	output rec_t       rec
);

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;
	logic               fire_s1;
	logic               rec_free;

	logic [POS_W-1:0]   pos_q;
	logic               fmt_q;
	logic [FIELD_W-1:0] day_q, month_q, cent_q, yr_lo_q, hour_q, minute_q;
	logic [YEAR_W-1:0]  year_q;

	logic [POS_W-1:0]   pos_d;
	logic               fmt_d;
	logic [FIELD_W-1:0] day_d, month_d, cent_d, yr_lo_d, hour_d, minute_d;
	logic [YEAR_W-1:0]  year_d;

	logic               is_digit;
	logic [3:0]         dig;

	logic               rec_valid_s2;
	rec_t               rec_s2;

	assign rec_free   = !rec_valid_s2 || rec_ready;
	assign fire_s1    = valid_s1 && (!last_s1 || rec_free);
	assign text_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	assign is_digit = (ch_s1 >= CHAR_ZERO) && (ch_s1 <= CHAR_NINE);
	assign dig      = 4'(ch_s1 - CHAR_ZERO);

	always_comb begin
		fmt_d    = fmt_q;
		day_d    = day_q;
		month_d  = month_q;
		year_d   = year_q;
		cent_d   = cent_q;
		yr_lo_d  = yr_lo_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		pos_d    = (pos_q < POS_SAT) ? pos_q + 5'd1 : pos_q;
		if (pos_q < TEXT_LEN) begin
			case (pos_q)
				POS_SLASH_A, POS_SLASH_B: begin
					if (ch_s1 != CHAR_SLASH) fmt_d = 1'b0;
				end
				POS_SPACE: begin
					if (ch_s1 != CHAR_SPACE) fmt_d = 1'b0;
				end
				POS_COLON: begin
					if (ch_s1 != CHAR_COLON) fmt_d = 1'b0;
				end
				default: begin
					if (!is_digit) begin
						fmt_d = 1'b0;
					end else if (pos_q <= POS_DAY_END) begin
						day_d = mul10_add7(day_q, dig);
					end else if (pos_q <= POS_MON_END) begin
						month_d = mul10_add7(month_q, dig);
					end else if (pos_q <= POS_YEAR_END) begin
						year_d = mul10_add14(year_q, dig);
						if (pos_q <= POS_CENT_END) cent_d = mul10_add7(cent_q, dig);
						else yr_lo_d = mul10_add7(yr_lo_q, dig);
					end else if (pos_q <= POS_HOUR_END) begin
						hour_d = mul10_add7(hour_q, dig);
					end else begin
						minute_d = mul10_add7(minute_q, dig);
					end
				end
			endcase
		end else begin
			fmt_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fmt_q    <= 1'b1;
			day_q    <= '0;
			month_q  <= '0;
			year_q   <= '0;
			cent_q   <= '0;
			yr_lo_q  <= '0;
			hour_q   <= '0;
			minute_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				pos_q    <= '0;
				fmt_q    <= 1'b1;
				day_q    <= '0;
				month_q  <= '0;
				year_q   <= '0;
				cent_q   <= '0;
				yr_lo_q  <= '0;
				hour_q   <= '0;
				minute_q <= '0;
			end else begin
				pos_q    <= pos_d;
				fmt_q    <= fmt_d;
				day_q    <= day_d;
				month_q  <= month_d;
				year_q   <= year_d;
				cent_q   <= cent_d;
				yr_lo_q  <= yr_lo_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s2 <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			rec_valid_s2 <= 1'b1;
		end else if (rec_ready) begin
			rec_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			rec_s2.fmt_ok <= fmt_d && (pos_d == TEXT_LEN);
			rec_s2.day    <= day_d;
			rec_s2.month  <= month_d;
			rec_s2.year   <= year_d;
			rec_s2.cent   <= cent_d;
			rec_s2.yr_lo  <= yr_lo_d;
			rec_s2.hour   <= hour_d;
			rec_s2.minute <= minute_d;
		end
	end

	assign rec_valid = rec_valid_s2;
	assign rec       = rec_s2;

endmodule

[sv/dttv_check.sv]
// date and time range checks and the result register
`timescale 1ns / 1ps

module dttv_check
	import dttv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               rec_valid,
	output logic               rec_ready,
	input  rec_t               rec,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] day,
	output logic [FIELD_W-1:0] month,
	output logic [YEAR_W-1:0]  year,
	output logic [FIELD_W-1:0] hour,
	output logic [FIELD_W-1:0] minute
);

	logic               valid_q;
	status_t            status_q;
	logic [FIELD_W-1:0] day_q, month_q, hour_q, minute_q;
	logic [YEAR_W-1:0]  year_q;

	logic               leap;
	logic [FIELD_W-1:0] lim;
	logic               date_ok;
	logic               time_ok;
	status_t            status_d;
	logic               take;

	// four-digit year: low pair zero means a century year
	assign leap = ((rec.year[1:0] == 2'b00) && (rec.yr_lo != '0)) ||
		((rec.yr_lo == '0) && (rec.cent[1:0] == 2'b00));
	assign lim = (rec.month == MONTH_FEB) ? (leap ? FEB_LEAP : FEB_COMMON)
		: month_days(rec.month);

	assign date_ok = (rec.month >= MONTH_FIRST) && (rec.month <= MONTH_LAST) &&
		(rec.year >= cfg.min_year) && (rec.year <= cfg.max_year) &&
		(rec.day >= DAY_FIRST) && (rec.day <= lim);
	assign time_ok = (rec.hour <= HOUR_MAX) && (rec.minute <= MINUTE_MAX);

	always_comb begin
		if (!rec.fmt_ok) status_d = STATUS_FORMAT;
		else if (!date_ok) status_d = STATUS_DATE;
		else if (!time_ok) status_d = STATUS_TIME;
		else status_d = STATUS_VALID;
	end

	assign rec_ready = !valid_q || result_ready;
	assign take      = rec_valid && rec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= status_d;
			day_q    <= rec.day;
			month_q  <= rec.month;
			year_q   <= rec.year;
			hour_q   <= rec.hour;
			minute_q <= rec.minute;
		end
	end

	assign result_valid = valid_q;
	assign status       = status_q;
	assign day          = day_q;
	assign month        = month_q;
	assign year         = year_q;
	assign hour         = hour_q;
	assign minute       = minute_q;

endmodule

[sv/date_time_text_validator_top.sv]
// top level of the date/time text validator
`timescale 1ns / 1ps

// Checks a "dd/mm/yyyy hh:mm" timestamp sent one character per transaction on the
// text channel, with last set on the final character. Characters are taken back to
// back, but a last character waits while the record register that feeds the checker
// is full. The text of one timestamp flows through an input register, the field
// accumulators, that record register and the result register; a full result register
// holds back only the last character of a following text, once the record register is
// full as well. status is 0 for valid, 1 for bad format (wrong length or misplaced
// character), 2 for bad date and 3 for bad time, checked in that order. The year bounds
// min_year (address 0x0, reset 1900) and max_year (address 0x4, reset 2100) must be
// written through the apb-style port only while the block is idle; nothing enforces it.

module date_time_text_validator_top
	import dttv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [6:0]  day,
	output logic [6:0]  month,
	output logic [13:0] year,
	output logic [6:0]  hour,
	output logic [6:0]  minute
);

	cfg_t cfg;
	rec_t rec;
	logic rec_valid;
	logic rec_ready;

	dttv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dttv_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.ch         (ch),
		.last       (last),
		.rec_valid  (rec_valid),
		.rec_ready  (rec_ready),
		.rec        (rec)
	);

	dttv_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.rec_valid    (rec_valid),
		.rec_ready    (rec_ready),
		.rec          (rec),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.day          (day),
		.month        (month),
		.year         (year),
		.hour         (hour),
		.minute       (minute)
	);

endmodule

[verif/date_time_text_validator_top_tb.sv]
// testbench for the date/time text validator: directed table, random timestamps, year bounds
`timescale 1ns / 1ps

module date_time_text_validator_top_tb;
	import dttv_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
	} stamp_t;

	typedef struct packed {
		logic [7:0] c;
		logic       lst;
		logic       typed;
		stamp_t     want;
	} char_item_t;

	localparam logic [2:0] ADDR_MIN_YEAR = {REG_MIN_YEAR, 2'b00};
	localparam logic [2:0] ADDR_MAX_YEAR = {REG_MAX_YEAR, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        text_valid = 1'b0;
	logic        text_ready;
	logic [7:0]  ch = '0;
	logic        last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  status;
	logic [6:0]  day;
	logic [6:0]  month;
	logic [13:0] year;
	logic [6:0]  hour;
	logic [6:0]  minute;

	// year bounds and text state of the predictor
	logic [YEAR_W-1:0]  lo_year = MIN_YEAR_RST;
	logic [YEAR_W-1:0]  hi_year = MAX_YEAR_RST;
	logic [POS_W-1:0]   txt_pos = '0;
	logic               fmt_good = 1'b1;
	logic [FIELD_W-1:0] acc_day = '0;
	logic [FIELD_W-1:0] acc_month = '0;
	logic [YEAR_W-1:0]  acc_year = '0;
	logic [FIELD_W-1:0] acc_hour = '0;
	logic [FIELD_W-1:0] acc_min = '0;

	stamp_t     stamp_q[$];
	char_item_t char_q[$];
	logic [7:0] text_buf[$];
	string      row_text[$];
	logic       row_typed[$];
	stamp_t     row_want[$];
	char_item_t cur;

	int chars_pushed = 0;
	int chars_taken = 0;
	int stamps_checked = 0;
	int mismatches = 0;
	int bound_settings = 1;
	int seen[4] = '{0, 0, 0, 0};
	logic gaps_off = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	date_time_text_validator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.ch(ch),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.day(day),
		.month(month),
		.year(year),
		.hour(hour),
		.minute(minute)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic date_good(input logic [FIELD_W-1:0] dd, input logic [FIELD_W-1:0] mm,
		input logic [YEAR_W-1:0] yy);
		logic [FIELD_W-1:0] top_day;
		logic leap;
		leap = ((yy % 14'd4) == 0 && (yy % 14'd100) != 0) || (yy % 14'd400) == 0;
		case (mm)
			MONTH_FEB: top_day = leap ? FEB_LEAP : FEB_COMMON;
			7'd4, 7'd6, 7'd9, 7'd11: top_day = 7'd30;
			default: top_day = 7'd31;
		endcase
		date_good = mm >= MONTH_FIRST && mm <= MONTH_LAST && yy >= lo_year && yy <= hi_year
			&& dd >= DAY_FIRST && dd <= top_day;
	endfunction

	task automatic parse_char(input logic [7:0] c, input logic lst, output stamp_t r);
		logic       is_digit;
		logic [3:0] d;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		d = is_digit ? c[3:0] : 4'd0;
		r = '0;
		if (txt_pos < TEXT_LEN) begin
			if (txt_pos == POS_SLASH_A || txt_pos == POS_SLASH_B) begin
				if (c != CHAR_SLASH) fmt_good = 1'b0;
			end else if (txt_pos == POS_SPACE) begin
				if (c != CHAR_SPACE) fmt_good = 1'b0;
			end else if (txt_pos == POS_COLON) begin
				if (c != CHAR_COLON) fmt_good = 1'b0;
			end else if (!is_digit) begin
				fmt_good = 1'b0;
			end else if (txt_pos <= POS_DAY_END) begin
				acc_day = acc_day * 7'd10 + {3'd0, d};
			end else if (txt_pos <= POS_MON_END) begin
				acc_month = acc_month * 7'd10 + {3'd0, d};
			end else if (txt_pos <= POS_YEAR_END) begin
				acc_year = acc_year * 14'd10 + {10'd0, d};
			end else if (txt_pos <= POS_HOUR_END) begin
				acc_hour = acc_hour * 7'd10 + {3'd0, d};
			end else begin
				acc_min = acc_min * 7'd10 + {3'd0, d};
			end
		end else begin
			fmt_good = 1'b0;
		end
		if (txt_pos < POS_SAT) txt_pos = txt_pos + 5'd1;
		if (lst) begin
			r.day = acc_day;
			r.month = acc_month;
			r.year = acc_year;
			r.hour = acc_hour;
			r.minute = acc_min;
			if (!fmt_good || txt_pos != TEXT_LEN) r.status = STATUS_FORMAT;
			else if (!date_good(acc_day, acc_month, acc_year)) r.status = STATUS_DATE;
			else if (acc_hour > HOUR_MAX || acc_min > MINUTE_MAX) r.status = STATUS_TIME;
			else r.status = STATUS_VALID;
			txt_pos = '0;
			fmt_good = 1'b1;
			acc_day = '0;
			acc_month = '0;
			acc_year = '0;
			acc_hour = '0;
			acc_min = '0;
		end
	endtask

	// text sender
	always @(posedge clk) begin
		stamp_t r;
		if (arst_n) begin
			if (text_valid && text_ready) begin
				parse_char(cur.c, cur.lst, r);
				if (cur.lst) stamp_q.push_back(cur.typed ? cur.want : r);
				chars_taken++;
			end
			if (!text_valid || text_ready) begin
				if (char_q.size() > 0 && (gaps_off || $urandom_range(99) >= 37)) begin
					cur = char_q.pop_front();
					text_valid <= 1'b1;
					ch <= cur.c;
					last <= cur.lst;
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk) begin
		stamp_t e;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (stamp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result status=%0d %0d/%0d/%0d %0d:%0d", $realtime,
							status, day, month, year, hour, minute);
				end else begin
					e = stamp_q.pop_front();
					stamps_checked++;
					seen[status]++;
					if (status !== e.status || day !== e.day || month !== e.month
						|| year !== e.year || hour !== e.hour || minute !== e.minute) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp %0d %0d/%0d/%0d %0d:%0d got %0d %0d/%0d/%0d %0d:%0d",
								$realtime, e.status, e.day, e.month, e.year, e.hour, e.minute,
								status, day, month, year, hour, minute);
					end
				end
			end
			if (!hold_done && chars_taken >= 500) begin
				hold_left <= 400;
				hold_done <= 1'b1;
				result_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= gaps_off || $urandom_range(99) >= 37;
			end
		end
	end

	task automatic add_row(input string s, input logic typed, input status_t st, input int dd,
		input int mm, input int yy, input int hh, input int mi);
		stamp_t e;
		e.status = st;
		e.day = dd[6:0];
		e.month = mm[6:0];
		e.year = yy[13:0];
		e.hour = hh[6:0];
		e.minute = mi[6:0];
		row_text.push_back(s);
		row_typed.push_back(typed);
		row_want.push_back(e);
	endtask

	task automatic flush_text(input logic typed, input stamp_t want);
		char_item_t it;
		for (int i = 0; i < text_buf.size(); i++) begin
			it.c = text_buf[i];
			it.lst = (i == text_buf.size() - 1);
			it.typed = typed;
			it.want = want;
			char_q.push_back(it);
		end
		chars_pushed += text_buf.size();
		text_buf.delete();
	endtask

	task automatic make_text;
		int dd, mm, yy, hh, mi, pick, n, at;
		string s;
		dd = ($urandom_range(99) < 75) ? $urandom_range(31, 1) : $urandom_range(99);
		mm = ($urandom_range(99) < 80) ? $urandom_range(12, 1) : $urandom_range(99);
		if (lo_year <= hi_year && $urandom_range(99) < 60) yy = $urandom_range(hi_year, lo_year);
		else yy = $urandom_range(9999);
		if ($urandom_range(99) < 15) begin
			// february around the leap day
			dd = $urandom_range(30, 28);
			mm = 2;
			yy = ($urandom_range(1) != 0) ? $urandom_range(99) * 100 : $urandom_range(2499) * 4;
		end
		hh = ($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(99);
		mi = ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(99);
		s = $sformatf("%02d/%02d/%04d %02d:%02d", dd, mm, yy, hh, mi);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		pick = $urandom_range(99);
		if (pick >= 94) begin
			text_buf.delete();
			n = $urandom_range(5, 1);
			repeat (n) text_buf.push_back(8'($urandom_range(255)));
		end else if (pick >= 88) begin
			n = $urandom_range(4, 1);
			repeat (n) text_buf.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(255))
				: 8'(CHAR_ZERO + $urandom_range(9)));
		end else if (pick >= 82) begin
			n = $urandom_range(15, 1);
			repeat (n) text_buf.delete(text_buf.size() - 1);
		end else if (pick >= 72) begin
			at = $urandom_range(15);
			text_buf[at] = 8'($urandom_range(255));
		end
	endtask

	task automatic random_texts(input int upto);
		while (chars_pushed < upto) begin
			make_text();
			flush_text(1'b0, '0);
		end
	endtask

	task automatic settle;
		while (chars_taken != chars_pushed || stamp_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [YEAR_W-1:0] val);
		logic [31:0] word;
		word = $urandom;
		word[YEAR_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_MIN_YEAR) lo_year = val;
		else hi_year = val;
	endtask

	task automatic set_bounds(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
		write_reg(ADDR_MIN_YEAR, lo);
		write_reg(ADDR_MAX_YEAR, hi);
		bound_settings++;
	endtask

	initial begin : main_seq
		string s;
		add_row("01/01/2000 00:00", 1'b1, STATUS_VALID, 1, 1, 2000, 0, 0);
		add_row("31/12/2100 23:59", 1'b1, STATUS_VALID, 31, 12, 2100, 23, 59);
		add_row("01/01/1900 00:00", 1'b1, STATUS_VALID, 1, 1, 1900, 0, 0);
		add_row("29/02/2000 12:30", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("29/02/1900 12:30", 1'b1, STATUS_DATE, 29, 2, 1900, 12, 30);
		add_row("29/02/2024 06:15", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("29/02/2023 06:15", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("31/04/2021 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("30/04/2021 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("00/05/2020 10:10", 1'b1, STATUS_DATE, 0, 5, 2020, 10, 10);
		add_row("15/13/2020 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/00/2020 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("31/12/1899 23:59", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("01/01/2101 00:00", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020 24:00", 1'b1, STATUS_TIME, 15, 6, 2020, 24, 0);
		add_row("15/06/2020 23:60", 1'b1, STATUS_TIME, 15, 6, 2020, 23, 60);
		add_row("99/99/9999 99:99", 1'b1, STATUS_DATE, 99, 99, 9999, 99, 99);
		add_row("15-06/2020 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020T10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020 10.10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("/:/06/2020 10:10", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020 10:1", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020 10:100", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("15/06/2020 10:10 extra", 1'b0, STATUS_VALID, 0, 0, 0, 0, 0);
		add_row("7", 1'b1, STATUS_FORMAT, 7, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < row_text.size(); k++) begin
			s = row_text[k];
			for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
			flush_text(row_typed[k], row_want[k]);
		end
		settle();

		// widest bounds, receiver hold-off lands here
		set_bounds(14'd0, 14'd9999);
		random_texts(800);
		settle();

		// single accepted year with no idling on either side
		gaps_off = 1'b1;
		set_bounds(14'd2000, 14'd2000);
		random_texts(1100);
		settle();
		gaps_off = 1'b0;

		// inverted bounds reject every year
		set_bounds(14'd5000, 14'd100);
		random_texts(1300);
		settle();

		set_bounds(14'($urandom_range(9999)), 14'($urandom_range(9999)));
		random_texts(1450);
		settle();

		set_bounds(MIN_YEAR_RST, MAX_YEAR_RST);
		random_texts(1550);
		settle();

		$display("sent %0d characters, checked %0d timestamps under %0d year-bound settings",
			chars_taken, stamps_checked, bound_settings);
		$display("status mix valid/format/date/time: %0d/%0d/%0d/%0d, mismatches: %0d",
			seen[0], seen[1], seen[2], seen[3], mismatches);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/dttv_pkg.sv
sv/dttv_cfg.sv
sv/dttv_parse.sv
sv/dttv_check.sv
sv/date_time_text_validator_top.sv
verif/date_time_text_validator_top_tb.sv
